[rtl/arec_pkg.sv]
// ----------------------------------------------------------------------------
// arec_pkg
// shared widths, constants and helpers of the adaptive order-0 range encoder
// ----------------------------------------------------------------------------
`default_nettype none

package arec_pkg;

    localparam int SYMBOLS   = 256;
    localparam int CNT_W     = 17;
    localparam int IDX_W     = 9;

    localparam logic [31:0]      RC_SETTLE = 32'h0100_0000;
    localparam logic [31:0]      RC_FLOOR  = 32'h0001_0000;
    localparam logic [31:0]      RC_FULL   = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(SYMBOLS);
    localparam logic [CNT_W-1:0] TOTAL_LIM = CNT_W'(65536);
    localparam logic [7:0]       INC_RST   = 8'd32;

    typedef struct packed {
        logic        emit;
        logic [31:0] rng;
    } norm_t;

    function automatic norm_t norm_check(input logic [31:0] low, input logic [31:0] rng);
        norm_t       r;
        logic [31:0] diff;
        diff   = low ^ (low + rng);
        r.emit = 1'b1;
        r.rng  = rng;
        if (diff >= RC_SETTLE) begin
            if (rng >= RC_FLOOR) begin
                r.emit = 1'b0;
            end else begin
                r.rng = (32'd0 - low) & (RC_FLOOR - 32'd1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/arec_div.sv]
// ----------------------------------------------------------------------------
// arec_div
// restoring divider, one quotient bit per cycle, 32-bit dividend
// ----------------------------------------------------------------------------
`default_nettype none

module arec_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [31:0]                dividend,
    input  wire logic [arec_pkg::CNT_W-1:0] divisor,
    output logic                            done,
    output logic [31:0]                     quotient
);

    logic [arec_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [31:0]                quo_reg, quo_next;
    logic [arec_pkg::CNT_W-1:0] dvs_reg, dvs_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [arec_pkg::CNT_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = arec_pkg::CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[arec_pkg::CNT_W-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/adaptive_range_encoder_order0_unit.sv]
// ----------------------------------------------------------------------------
// adaptive_range_encoder_order0_unit
// adaptive order-0 byte encoder on a 32-bit carryless range coder
// ----------------------------------------------------------------------------
// channel   dir  tdata / fields                 tuser / tlast
// s_*       in   tdata[7:0] symbol              tuser[0] func (1 = flush)
// m_*       out  tdata[7:0] out_byte            tlast last_of_run
// apb       in   0x0 freq_increment[7:0]        -
//
// one item at a time; an encode walks the counts up to the symbol on the
// count memory port, divides the range by the total, multiplies and adds,
// emits up to 4 normalization beats and writes back the updated count
// a count overflow adds a rescale pass over the count memory that halves each count
// a flush emits 4 beats and then resets the coder state; output stalls hold the
// normalization and flush; reset is synchronous; counts read 1 without valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_range_encoder_order0_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol
    input  wire logic [0:0] s_tuser,   // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_DIV, S_MUL, S_ADD, S_NORM, S_UPD, S_RESC, S_FLUSH
    } state_t;

    localparam int CW = arec_pkg::CNT_W;
    localparam int IW = arec_pkg::IDX_W;

    state_t            state_reg, state_next;
    logic [7:0]        inc_reg;
    logic [31:0]       low_reg, low_next;
    logic [31:0]       rng_reg, rng_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     cum_reg, cum_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [7:0]        sym_reg, sym_next;
    logic [IW-1:0]     addr_reg, addr_next;
    logic [2:0]        n_reg, n_next;
    logic [31:0]       q_reg, q_next;
    logic [31:0]       pl_reg, pl_next;
    logic [31:0]       pr_reg, pr_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic              ol_reg, ol_next;

    logic [CW-1:0]     mem [arec_pkg::SYMBOLS];
    logic [arec_pkg::SYMBOLS-1:0] vbit_reg;
    logic [CW-1:0]     mem_q_reg;
    logic              vq_reg;
    logic              rd_vld_reg;
    logic [7:0]        rd_idx_reg;
    logic              rd_en;
    logic [7:0]        rd_addr;
    logic              wr_en;
    logic [7:0]        wr_addr;
    logic [CW-1:0]     wr_data;
    logic              vclr;
    logic [CW-1:0]     cval;
    logic [CW-1:0]     half;
    logic              can_push;
    logic              s_acc;
    logic              cfg_wr;
    arec_pkg::norm_t   nc, ns;
    logic [31:0]       low_s, rng_s;
    logic              div_start;
    logic              div_done;
    logic [31:0]       quo;
    logic [48:0]       mul_l, mul_r;

    assign pready   = 1'b1;
    assign prdata   = {24'd0, inc_reg};
    assign cfg_wr   = psel && penable && pwrite && (paddr == 2'd0);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign can_push = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = ob_reg;
    assign m_tlast  = ol_reg;
    assign cval     = vq_reg ? mem_q_reg : CW'(1);
    assign half     = (cval >> 1) | CW'(1);
    assign nc       = arec_pkg::norm_check(low_reg, rng_reg);
    assign low_s    = {low_reg[23:0], 8'd0};
    assign rng_s    = {nc.rng[23:0], 8'd0};
    assign ns       = arec_pkg::norm_check(low_s, rng_s);
    assign mul_l    = q_reg * cum_reg;
    assign mul_r    = q_reg * cnt_reg;

    arec_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rng_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        rng_next   = rng_reg;
        total_next = total_reg;
        cum_next   = cum_reg;
        cnt_next   = cnt_reg;
        sym_next   = sym_reg;
        addr_next  = addr_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        pl_next    = pl_reg;
        pr_next    = pr_reg;
        ov_next    = ov_reg && !m_tready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_reg[7:0];
        wr_en      = 1'b0;
        wr_addr    = sym_reg;
        wr_data    = cnt_reg;
        vclr       = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    sym_next  = s_tdata;
                    cum_next  = '0;
                    addr_next = '0;
                    n_next    = '0;
                    state_next = s_tuser[0] ? S_FLUSH : S_WALK;
                end
            end
            S_WALK: begin
                if (addr_reg <= {1'b0, sym_reg}) begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + IW'(1);
                end
                if (rd_vld_reg) begin
                    if (rd_idx_reg == sym_reg) begin
                        cnt_next   = cval;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end else begin
                        cum_next = cum_reg + cval;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    q_next     = quo;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                pl_next    = mul_l[31:0];
                pr_next    = mul_r[31:0];
                state_next = S_ADD;
            end
            S_ADD: begin
                low_next   = low_reg + pl_reg;
                rng_next   = pr_reg;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (n_reg == 3'd4 || !nc.emit) begin
                    rng_next   = nc.rng;
                    state_next = S_UPD;
                end else if (can_push) begin
                    ov_next  = 1'b1;
                    ob_next  = low_reg[31:24];
                    ol_next  = (n_reg == 3'd3) || !ns.emit;
                    low_next = low_s;
                    rng_next = rng_s;
                    n_next   = n_reg + 3'd1;
                end
            end
            S_UPD: begin
                wr_en      = 1'b1;
                wr_data    = cnt_reg + CW'(inc_reg);
                total_next = total_reg + CW'(inc_reg);
                addr_next  = '0;
                if (total_next >= arec_pkg::TOTAL_LIM) begin
                    total_next = '0;
                    state_next = S_RESC;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RESC: begin
                if (addr_reg < IW'(arec_pkg::SYMBOLS)) begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + IW'(1);
                end
                if (rd_vld_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_idx_reg;
                    wr_data    = half;
                    total_next = total_reg + half;
                    if (rd_idx_reg == 8'(arec_pkg::SYMBOLS - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (n_reg == 3'd4) begin
                    low_next   = '0;
                    rng_next   = arec_pkg::RC_FULL;
                    total_next = arec_pkg::TOTAL_RST;
                    vclr       = 1'b1;
                    state_next = S_IDLE;
                end else if (can_push) begin
                    ov_next  = 1'b1;
                    ob_next  = low_reg[31:24];
                    ol_next  = (n_reg == 3'd3);
                    low_next = low_s;
                    n_next   = n_reg + 3'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            inc_reg    <= arec_pkg::INC_RST;
            low_reg    <= '0;
            rng_reg    <= arec_pkg::RC_FULL;
            total_reg  <= arec_pkg::TOTAL_RST;
            ov_reg     <= 1'b0;
            vbit_reg   <= '0;
            rd_vld_reg <= 1'b0;
            addr_reg   <= '0;
            n_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            if (cfg_wr) begin
                inc_reg <= pwdata[7:0];
            end
            low_reg    <= low_next;
            rng_reg    <= rng_next;
            total_reg  <= total_next;
            ov_reg     <= ov_next;
            rd_vld_reg <= rd_en;
            addr_reg   <= addr_next;
            n_reg      <= n_next;
            if (vclr) begin
                vbit_reg <= '0;
            end else if (wr_en) begin
                vbit_reg[wr_addr] <= 1'b1;
            end
        end
        cum_reg    <= cum_next;
        cnt_reg    <= cnt_next;
        sym_reg    <= sym_next;
        q_reg      <= q_next;
        pl_reg     <= pl_next;
        pr_reg     <= pr_next;
        ob_reg     <= ob_next;
        ol_reg     <= ol_next;
        rd_idx_reg <= rd_addr;
        vq_reg     <= vbit_reg[rd_addr];
    end

    // count memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> total_reg >= arec_pkg::TOTAL_RST
                                && total_reg < arec_pkg::TOTAL_LIM)
        else $error("total out of range in idle");

    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && rd_vld_reg) |-> rd_idx_reg <= sym_reg)
        else $error("count walk passed the symbol");

    a_encode_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tuser[0]) |=> state_reg == S_WALK)
        else $error("encode beat did not start a walk");

    a_flush_beats: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && n_reg == 3'd4) |-> ol_reg)
        else $error("flush ended without last beat");

endmodule

`default_nettype wire

[test/adaptive_range_encoder_order0_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_range_encoder_order0_unit_tb
// drives symbols and flushes into the order-0 range encoder and checks the
// coded byte stream against an in-bench adaptive range coder with its own
// counts, bounds and increment register, under random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

class range_coder_scoreboard;
    typedef struct {
        bit [7:0] byte_val;
        bit       last;
    } coded_beat_t;

    coded_beat_t coded_q[$];
    bit [31:0]   low_bound;
    bit [31:0]   span;
    bit [31:0]   counts[256];
    bit [31:0]   total;
    bit [7:0]    increment;
    int          mismatches;

    function void clear_coder();
        low_bound = 32'd0;
        span      = 32'hFFFF_FFFF;
        foreach (counts[i]) counts[i] = 32'd1;
        total     = 32'd256;
    endfunction

    function void note_input(bit flush, bit [7:0] sym);
        bit [31:0]   cum;
        int          n;
        coded_beat_t b;
        if (flush) begin
            for (int k = 0; k < 4; k++) begin
                b.byte_val = low_bound[31:24];
                b.last     = (k == 3);
                coded_q    = {coded_q, b};
                low_bound  = low_bound << 8;
            end
            clear_coder();
            return;
        end
        cum = 32'd0;
        for (int i = 0; i < sym; i++) cum += counts[i];
        span      = span / total;
        low_bound = low_bound + cum * span;
        span      = span * counts[sym];
        n = 0;
        forever begin
            if ((low_bound ^ (low_bound + span)) >= 32'h0100_0000) begin
                if (span >= 32'h0001_0000) break;
                span = (32'd0 - low_bound) & 32'h0000_FFFF;
            end
            if (n >= 4) break;
            b.byte_val = low_bound[31:24];
            b.last     = 1'b0;
            coded_q    = {coded_q, b};
            n++;
            low_bound = low_bound << 8;
            span      = span << 8;
        end
        if (n > 0) coded_q[$].last = 1'b1;
        counts[sym] += increment;
        total       += increment;
        if (total >= 32'h0001_0000) begin
            total = 32'd0;
            foreach (counts[i]) begin
                counts[i] = (counts[i] >> 1) | 32'd1;
                total    += counts[i];
            end
        end
    endfunction

    function void check_beat(bit [7:0] byte_val, bit last);
        coded_beat_t e;
        if (coded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: byte %02h last %0b", byte_val, last);
            return;
        end
        e = coded_q.pop_front();
        if (e.byte_val !== byte_val || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                         e.byte_val, e.last, byte_val, last);
        end
    endfunction
endclass

module adaptive_range_encoder_order0_unit_tb;

    typedef enum bit {FN_ENCODE = 1'b0, FN_FLUSH = 1'b1} func_kind_t;
    localparam logic [1:0] REG_FREQ_INC = 2'd0;
    localparam int         SETTLE_CYCLES = 700;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] symbol
    logic [0:0]  s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    range_coder_scoreboard coder_sb;
    bit calm;

    adaptive_range_encoder_order0_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // valid stays up after the accepting edge until the next beat or a gap
    task automatic send_item(func_kind_t fn, bit [7:0] sym);
        while (!calm && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        coder_sb.note_input(fn == FN_FLUSH, sym);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (coder_sb.coded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_increment(bit [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_FREQ_INC;
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        coder_sb.increment = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_items(int count, int flush_pct, int calm_from, int calm_to);
        for (int i = 0; i < count; i++) begin
            calm = (i >= calm_from && i < calm_to);
            if ($urandom_range(99) < flush_pct)
                send_item(FN_FLUSH, 8'($urandom));
            else
                send_item(FN_ENCODE, 8'($urandom));
        end
        calm = 1'b0;
    endtask

    // output side
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) coder_sb.check_beat(m_tdata, m_tlast);
            @(negedge aclk);
            m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        coder_sb = new();
        coder_sb.clear_coder();
        coder_sb.increment = 8'd32;
        calm     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 2'd0;
        pwdata   = 32'd0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        send_item(FN_FLUSH, 8'h00);
        send_item(FN_ENCODE, 8'h00);
        send_item(FN_ENCODE, 8'hFF);
        send_item(FN_ENCODE, 8'h80);
        send_item(FN_ENCODE, 8'h55);
        send_item(FN_FLUSH, 8'hFF);
        drain();

        // large increment with no flush reaches the count rescale
        write_increment(8'd255);
        random_items(258, 0, 100, 160);
        send_item(FN_FLUSH, 8'h00);
        drain();

        if (coder_sb.mismatches == 0 && coder_sb.coded_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
